>>> hw/rtl/kdeq_pkg.sv
// Shared constants, action codes and the queued event record for the key
// debounce event queue. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package kdeq_pkg;

  localparam int KEYS            = 3;
  localparam int KEY_W           = 2;
  localparam int TIME_W          = 32;
  localparam int HELD_W          = 16;
  localparam int CNT_W           = 32;
  localparam int DEB_W           = 16;
  localparam int QUEUE_DEPTH_DEF = 8;

  localparam logic [DEB_W-1:0]  DEBOUNCE_RESET = 16'd20;
  localparam logic [HELD_W-1:0] HELD_MAX       = 16'hFFFF;

  localparam logic [2:0] ACT_START = 3'd0;
  localparam logic [2:0] ACT_SAMPLE = 3'd1;
  localparam logic [2:0] ACT_POP   = 3'd2;
  localparam logic [2:0] ACT_FLUSH = 3'd3;
  localparam logic [2:0] ACT_CLEAR = 3'd4;

  localparam logic EDGE_PRESS   = 1'b0;
  localparam logic EDGE_RELEASE = 1'b1;

  typedef struct packed {
    logic [HELD_W-1:0] held;
    logic [TIME_W-1:0] time_ms;
    logic              edge_kind;
    logic [KEY_W-1:0]  key;
  } event_t;

endpackage

`default_nettype wire

>>> hw/rtl/key_debounce_event_queue.sv
// Top level of the key debounce event queue: per-key debounce state, event
// queue in flip-flops, result register with a skid stage. Uses kdeq_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Three key lines are debounced against a programmable window (cfg_data, in
// milliseconds, reset 20). Each input beat carries an action in s_tuser and
// the key levels, timestamp and a key selector in s_tdata; every input beat
// yields one output beat with the popped event (if any) and status taken
// after the action. A press or release that survives the window is queued
// for a later pop; a full queue drops and counts the event. All work for a
// beat is one pass of logic between the input handshake and the result
// register, so one beat is taken per cycle unless the skid entry is full. A
// two-entry result/skid stage keeps the slave side open for one beat while
// the master side stalls; that beat's result waits in the skid entry.
module key_debounce_event_queue #(
  parameter int QUEUE_DEPTH = kdeq_pkg::QUEUE_DEPTH_DEF,
  localparam int LVL_W   = $clog2(QUEUE_DEPTH + 1),
  localparam int OUT_W   = ((119 + LVL_W + 7) / 8) * 8
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [kdeq_pkg::DEB_W-1:0] cfg_data,   // debounce_ms
  input  wire logic                     s_tvalid,
  output logic                          s_tready,
  input  wire logic [39:0]              s_tdata,    // raw_keys, now_ms, key_select
  input  wire logic [2:0]               s_tuser,    // action
  output logic                          m_tvalid,
  input  wire logic                     m_tready,
  // event_key, event_edge, event_time_ms, event_held_ms, pressed_mask,
  // dropped_count, bounce_count, queue_level, started
  output logic [OUT_W-1:0]              m_tdata,
  output logic                          m_tuser     // event_valid
);
  import kdeq_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int SUM_W = LVL_W + 1;
  localparam int J_W   = $clog2(KEYS + 1);
  localparam int RES_W = 119 + LVL_W;

  // input fields
  logic [2:0]        action;
  logic [KEYS-1:0]   raw_keys;
  logic [TIME_W-1:0] now_ms;
  logic [1:0]        key_select;
  logic              accept;

  assign action     = s_tuser;
  assign raw_keys   = s_tdata[2:0];
  assign now_ms     = s_tdata[34:3];
  assign key_select = s_tdata[36:35];
  assign accept     = s_tvalid && s_tready;

  // state
  logic [DEB_W-1:0]  debounce_ms;
  logic [KEYS-1:0]   raw_level, raw_level_next;
  logic [KEYS-1:0]   stable_level, stable_level_next;
  logic [TIME_W-1:0] change_time [KEYS];
  logic [TIME_W-1:0] change_time_next [KEYS];
  logic [TIME_W-1:0] press_time [KEYS];
  logic [TIME_W-1:0] press_time_next [KEYS];
  logic [CNT_W-1:0]  bounce_counter [KEYS];
  logic [CNT_W-1:0]  bounce_counter_next [KEYS];
  event_t            event_store [QUEUE_DEPTH];
  logic [PTR_W-1:0]  queue_head, queue_head_next;
  logic [LVL_W-1:0]  queue_fill, queue_fill_next;
  logic [CNT_W-1:0]  drop_counter, drop_counter_next;
  logic              started_flag, started_flag_next;

  // queue writes from this beat
  logic              push_we [KEYS];
  logic [PTR_W-1:0]  push_slot [KEYS];
  event_t            push_evt [KEYS];

  // result
  logic              res_valid;
  event_t            res_evt;
  logic [CNT_W-1:0]  res_bounce;
  logic [RES_W-1:0]  res_data;

  assign cfg_ready = 1'b1;

  always_comb begin : next_state
    logic [J_W-1:0]    n_push;
    logic [J_W-1:0]    n_drop;
    logic [SUM_W-1:0]  occ;
    logic [SUM_W-1:0]  pos;
    logic [TIME_W-1:0] diff;
    logic              lv;
    logic              want;
    event_t            evt;

    raw_level_next    = raw_level;
    stable_level_next = stable_level;
    change_time_next  = change_time;
    press_time_next   = press_time;
    bounce_counter_next = bounce_counter;
    queue_head_next   = queue_head;
    queue_fill_next   = queue_fill;
    drop_counter_next = drop_counter;
    started_flag_next = started_flag;
    res_valid         = 1'b0;
    res_evt           = '0;
    n_push            = '0;
    n_drop            = '0;
    occ               = '0;
    pos               = '0;
    diff              = '0;
    lv                = 1'b0;
    want              = 1'b0;
    evt               = '0;
    for (int i = 0; i < KEYS; i++) begin
      push_we[i]   = 1'b0;
      push_slot[i] = '0;
      push_evt[i]  = '0;
    end

    unique case (action)
      ACT_START: begin
        queue_head_next   = '0;
        queue_fill_next   = '0;
        drop_counter_next = '0;
        started_flag_next = 1'b1;
        for (int i = 0; i < KEYS; i++) begin
          raw_level_next[i]      = raw_keys[i];
          stable_level_next[i]   = raw_keys[i];
          change_time_next[i]    = now_ms;
          press_time_next[i]     = raw_keys[i] ? now_ms : '0;
          bounce_counter_next[i] = '0;
        end
      end
      ACT_SAMPLE: begin
        if (started_flag) begin
          for (int i = 0; i < KEYS; i++) begin
            lv   = raw_keys[i];
            want = 1'b0;
            evt  = '0;
            if (lv != raw_level[i]) begin
              raw_level_next[i]   = lv;
              change_time_next[i] = now_ms;
              if (lv == stable_level[i])
                bounce_counter_next[i] = bounce_counter[i] + 1'b1;
            end else if (lv != stable_level[i] &&
                         (now_ms - change_time[i]) >= {16'b0, debounce_ms}) begin
              want        = 1'b1;
              evt.key     = KEY_W'(i);
              evt.time_ms = change_time[i];
              stable_level_next[i] = lv;
              if (lv) begin
                press_time_next[i] = change_time[i];
                evt.edge_kind      = EDGE_PRESS;
                evt.held           = '0;
              end else begin
                diff = change_time[i] - press_time[i];
                press_time_next[i] = '0;
                evt.edge_kind      = EDGE_RELEASE;
                evt.held           = (|diff[TIME_W-1:HELD_W]) ? HELD_MAX
                                                             : diff[HELD_W-1:0];
              end
            end
            // slot allocation in key order; overflow drops once full
            if (want) begin
              occ = SUM_W'(queue_fill) + SUM_W'(n_push);
              if (occ < SUM_W'(QUEUE_DEPTH)) begin
                pos = SUM_W'(queue_head) + occ;
                if (pos >= SUM_W'(QUEUE_DEPTH))
                  pos = pos - SUM_W'(QUEUE_DEPTH);
                push_we[i]   = 1'b1;
                push_slot[i] = pos[PTR_W-1:0];
                push_evt[i]  = evt;
                n_push       = n_push + 1'b1;
              end else begin
                n_drop = n_drop + 1'b1;
              end
            end
          end
          queue_fill_next   = queue_fill + LVL_W'(n_push);
          drop_counter_next = drop_counter + CNT_W'(n_drop);
        end
      end
      ACT_POP: begin
        if (queue_fill != '0) begin
          res_valid       = 1'b1;
          res_evt         = event_store[queue_head];
          queue_fill_next = queue_fill - 1'b1;
          if (SUM_W'(queue_head) + 1'b1 >= SUM_W'(QUEUE_DEPTH))
            queue_head_next = '0;
          else
            queue_head_next = queue_head + 1'b1;
        end
      end
      ACT_FLUSH: begin
        queue_head_next = '0;
        queue_fill_next = '0;
      end
      ACT_CLEAR: begin
        drop_counter_next = '0;
        for (int i = 0; i < KEYS; i++)
          bounce_counter_next[i] = '0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (32'(key_select) < KEYS)
      res_bounce = bounce_counter_next[key_select];
    else
      res_bounce = '0;
  end

  assign res_data = {started_flag_next, queue_fill_next, res_bounce, drop_counter_next,
                     stable_level_next, res_evt.held, res_evt.time_ms,
                     res_evt.edge_kind, res_evt.key};

  // control and per-key state
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms  <= DEBOUNCE_RESET;
      raw_level    <= '0;
      stable_level <= '0;
      queue_head   <= '0;
      queue_fill   <= '0;
      drop_counter <= '0;
      started_flag <= 1'b0;
      for (int i = 0; i < KEYS; i++) begin
        change_time[i]    <= '0;
        press_time[i]     <= '0;
        bounce_counter[i] <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready)
        debounce_ms <= cfg_data;
      if (accept) begin
        raw_level      <= raw_level_next;
        stable_level   <= stable_level_next;
        change_time    <= change_time_next;
        press_time     <= press_time_next;
        bounce_counter <= bounce_counter_next;
        queue_head     <= queue_head_next;
        queue_fill     <= queue_fill_next;
        drop_counter   <= drop_counter_next;
        started_flag   <= started_flag_next;
      end
    end
  end

  // event store: no reset, entries are read only after being written
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < KEYS; i++)
        if (push_we[i])
          event_store[push_slot[i]] <= push_evt[i];
    end
  end

  // result register plus skid stage
  logic             out_valid, skid_valid;
  logic [RES_W-1:0] out_data, skid_data;
  logic             out_user, skid_user;
  logic             out_load;

  assign s_tready = !skid_valid;
  assign out_load = !out_valid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_load) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (skid_valid) begin
        out_data <= skid_data;
        out_user <= skid_user;
      end else if (accept) begin
        out_data <= res_data;
        out_user <= res_valid;
      end
    end else if (accept) begin
      skid_data <= res_data;
      skid_user <= res_valid;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = OUT_W'(out_data);
  assign m_tuser  = out_user;

endmodule

`default_nettype wire

>>> tb/sv/kdeq_event_checker.sv
`timescale 1ns / 1ps
// Checker for key_debounce_event_queue: follows the config, input and output
// channels, keeps its own debounce and queue model, compares every output beat.
// Depends on kdeq_pkg.

module kdeq_event_checker
  import kdeq_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF,
  parameter int OUT_W = 128
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_valid,
  input  wire logic             cfg_ready,
  input  wire logic [DEB_W-1:0] cfg_data,
  input  wire logic             s_tvalid,
  input  wire logic             s_tready,
  input  wire logic [39:0]      s_tdata,
  input  wire logic [2:0]       s_tuser,
  input  wire logic             m_tvalid,
  input  wire logic             m_tready,
  input  wire logic [OUT_W-1:0] m_tdata,
  input  wire logic             m_tuser,
  output int                    pending,
  output int                    fails
);

  localparam int LVL_W      = $clog2(DEPTH + 1);
  localparam int LVL_LSB    = 118;
  localparam int REPORT_MAX = 10;

  typedef struct packed {
    logic              ev_valid;
    logic [KEY_W-1:0]  ev_key;
    logic              ev_edge;
    logic [TIME_W-1:0] ev_time;
    logic [HELD_W-1:0] ev_held;
    logic [KEYS-1:0]   mask;
    logic [CNT_W-1:0]  drops;
    logic [CNT_W-1:0]  bounces;
    logic [LVL_W-1:0]  level;
    logic              started;
  } status_t;

  logic [DEB_W-1:0]  window_ms;
  logic [KEYS-1:0]   raw_lv;
  logic [KEYS-1:0]   stable_lv;
  logic [TIME_W-1:0] changed_at [KEYS];
  logic [TIME_W-1:0] pressed_at [KEYS];
  logic [CNT_W-1:0]  key_bounces [KEYS];
  event_t            ev_ring [DEPTH];
  int unsigned       ring_head;
  int unsigned       ring_fill;
  logic [CNT_W-1:0]  drop_total;
  logic              seeded;
  status_t           awaited_status [$];
  int                n_bad = 0;
  int                n_out = 0;

  function automatic void wipe_model();
    window_ms  = DEBOUNCE_RESET;
    raw_lv     = '0;
    stable_lv  = '0;
    for (int k = 0; k < KEYS; k++) begin
      changed_at[k]  = '0;
      pressed_at[k]  = '0;
      key_bounces[k] = '0;
    end
    ring_head  = 0;
    ring_fill  = 0;
    drop_total = '0;
    seeded     = 1'b0;
    awaited_status.delete();
  endfunction

  function automatic void queue_event(input int k, input logic kind,
                                      input logic [TIME_W-1:0] stamp,
                                      input logic [HELD_W-1:0] held);
    int unsigned slot;
    if (ring_fill >= DEPTH) begin
      drop_total = drop_total + 1'b1;
      return;
    end
    slot = (ring_head + ring_fill) % DEPTH;
    ev_ring[slot].key       = KEY_W'(k);
    ev_ring[slot].edge_kind = kind;
    ev_ring[slot].time_ms   = stamp;
    ev_ring[slot].held      = held;
    ring_fill++;
  endfunction

  // One input beat through the model; returns the status it should produce.
  function automatic status_t debounce_step(input logic [2:0] act,
                                            input logic [KEYS-1:0] keys,
                                            input logic [TIME_W-1:0] now,
                                            input logic [KEY_W-1:0] sel);
    status_t res;
    logic [TIME_W-1:0] elapsed;
    logic [TIME_W-1:0] span;
    res = '0;
    case (act)
      ACT_START: begin
        ring_head  = 0;
        ring_fill  = 0;
        drop_total = '0;
        for (int k = 0; k < KEYS; k++) begin
          raw_lv[k]      = keys[k];
          stable_lv[k]   = keys[k];
          changed_at[k]  = now;
          pressed_at[k]  = keys[k] ? now : '0;
          key_bounces[k] = '0;
        end
        seeded = 1'b1;
      end
      ACT_SAMPLE: begin
        if (seeded) begin
          for (int k = 0; k < KEYS; k++) begin
            elapsed = now - changed_at[k];
            if (keys[k] != raw_lv[k]) begin
              raw_lv[k]     = keys[k];
              changed_at[k] = now;
              if (keys[k] == stable_lv[k]) key_bounces[k] = key_bounces[k] + 1'b1;
            end else if (keys[k] != stable_lv[k] && elapsed >= TIME_W'(window_ms)) begin
              if (keys[k]) begin
                stable_lv[k]  = 1'b1;
                pressed_at[k] = changed_at[k];
                queue_event(k, EDGE_PRESS, changed_at[k], '0);
              end else begin
                span          = changed_at[k] - pressed_at[k];
                stable_lv[k]  = 1'b0;
                pressed_at[k] = '0;
                queue_event(k, EDGE_RELEASE, changed_at[k],
                            (span > TIME_W'(HELD_MAX)) ? HELD_MAX : span[HELD_W-1:0]);
              end
            end
          end
        end
      end
      ACT_POP: begin
        if (ring_fill != 0) begin
          res.ev_valid = 1'b1;
          res.ev_key   = ev_ring[ring_head].key;
          res.ev_edge  = ev_ring[ring_head].edge_kind;
          res.ev_time  = ev_ring[ring_head].time_ms;
          res.ev_held  = ev_ring[ring_head].held;
          ring_head    = (ring_head + 1) % DEPTH;
          ring_fill--;
        end
      end
      ACT_FLUSH: begin
        ring_head = 0;
        ring_fill = 0;
      end
      ACT_CLEAR: begin
        drop_total = '0;
        for (int k = 0; k < KEYS; k++) key_bounces[k] = '0;
      end
      default: ;
    endcase
    res.mask    = stable_lv;
    res.drops   = drop_total;
    if (sel < KEYS) res.bounces = key_bounces[sel];
    res.level   = LVL_W'(ring_fill);
    res.started = seeded;
    return res;
  endfunction

  function automatic string show(input status_t s);
    return $sformatf({"valid=%0d key=%0d edge=%0d t=%h held=%0d mask=%b drops=%0d ",
                      "bounces=%0d level=%0d started=%0d"},
                     s.ev_valid, s.ev_key, s.ev_edge, s.ev_time, s.ev_held, s.mask,
                     s.drops, s.bounces, s.level, s.started);
  endfunction

  function automatic string differing_fields(input status_t want, input status_t got);
    string names;
    names = "";
    if (got.ev_valid !== want.ev_valid) names = {names, " event_valid"};
    if (got.ev_key   !== want.ev_key)   names = {names, " event_key"};
    if (got.ev_edge  !== want.ev_edge)  names = {names, " event_edge"};
    if (got.ev_time  !== want.ev_time)  names = {names, " event_time_ms"};
    if (got.ev_held  !== want.ev_held)  names = {names, " event_held_ms"};
    if (got.mask     !== want.mask)     names = {names, " pressed_mask"};
    if (got.drops    !== want.drops)    names = {names, " dropped_count"};
    if (got.bounces  !== want.bounces)  names = {names, " bounce_count"};
    if (got.level    !== want.level)    names = {names, " queue_level"};
    if (got.started  !== want.started)  names = {names, " started"};
    return names;
  endfunction

  initial wipe_model();

  always @(posedge clk) begin
    status_t got;
    status_t want;
    string   bad;
    if (rst) begin
      wipe_model();
    end else begin
      // output side first: a beat can never answer an input taken at this edge
      if (m_tvalid && m_tready) begin
        got.ev_valid = m_tuser;
        got.ev_key   = m_tdata[1:0];
        got.ev_edge  = m_tdata[2];
        got.ev_time  = m_tdata[34:3];
        got.ev_held  = m_tdata[50:35];
        got.mask     = m_tdata[53:51];
        got.drops    = m_tdata[85:54];
        got.bounces  = m_tdata[117:86];
        got.level    = m_tdata[LVL_LSB +: LVL_W];
        got.started  = m_tdata[LVL_LSB + LVL_W];
        n_out++;
        if (awaited_status.size() == 0) begin
          n_bad++;
          if (n_bad <= REPORT_MAX)
            $display("%0t: output beat %0d with nothing outstanding: %s",
                     $realtime, n_out, show(got));
        end else begin
          want = awaited_status.pop_front();
          bad  = differing_fields(want, got);
          if (bad != "") begin
            n_bad++;
            if (n_bad <= REPORT_MAX) begin
              $display("%0t: mismatch on output beat %0d in%s", $realtime, n_out, bad);
              $display("  expected %s", show(want));
              $display("  actual   %s", show(got));
            end
          end
        end
      end
      if (cfg_valid && cfg_ready) window_ms = cfg_data;
      if (s_tvalid && s_tready)
        awaited_status.push_back(debounce_step(s_tuser, s_tdata[2:0], s_tdata[34:3],
                                               s_tdata[36:35]));
    end
    pending <= awaited_status.size();
    fails   <= n_bad;
  end

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Testbench top for key_debounce_event_queue: clock, reset, stimulus, output
// back-pressure and verdict. Uses kdeq_pkg and kdeq_event_checker.

module tb_top;
  import kdeq_pkg::*;

  localparam int QDEPTH      = QUEUE_DEPTH_DEF;
  localparam int LVL_W       = $clog2(QDEPTH + 1);
  localparam int OUT_W       = ((119 + LVL_W + 7) / 8) * 8;
  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_CYCLES = 80;
  localparam int PHASES      = 6;
  localparam int PHASE_BEATS = 155;

  localparam logic [2:0] ACT_SPARE_FIRST = 3'd5;
  localparam logic [2:0] ACT_SPARE_LAST  = 3'd7;

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             cfg_valid = 1'b0;
  logic [DEB_W-1:0] cfg_data  = '0;
  logic             s_tvalid  = 1'b0;
  logic [39:0]      s_tdata   = '0;   // raw_keys, now_ms, key_select
  logic [2:0]       s_tuser   = '0;   // action
  logic             m_tready  = 1'b0;
  wire              cfg_ready;
  wire              s_tready;
  wire              m_tvalid;
  // event_key, event_edge, event_time_ms, event_held_ms, pressed_mask,
  // dropped_count, bounce_count, queue_level, started
  wire [OUT_W-1:0]  m_tdata;
  wire              m_tuser;        // event_valid

  int               pending;
  int               fails;
  int unsigned      gap_pct   = 0;
  int unsigned      stall_pct = 0;
  int               pop_share = 22;
  int unsigned      squeeze_ask  = 0;
  int unsigned      squeeze_seen = 0;
  int unsigned      hold_left    = 0;
  int unsigned      quiet        = 0;
  logic [DEB_W-1:0] window = DEBOUNCE_RESET;
  logic [31:0]      now_ms = '0;
  logic [KEYS-1:0]  target = '0;

  key_debounce_event_queue #(.QUEUE_DEPTH(QDEPTH)) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  kdeq_event_checker #(.DEPTH(QDEPTH), .OUT_W(OUT_W)) chk (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .pending   (pending),
    .fails     (fails)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // output back-pressure; a squeeze request holds ready low for a long stretch
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (squeeze_ask != squeeze_seen) begin
      squeeze_seen <= squeeze_ask;
      hold_left    <= HOLD_CYCLES;
      m_tready     <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet == STALL_LIMIT) begin
        $display("key_debounce_event_queue verification failed");
        $finish;
      end
    end
  end

  task automatic put_beat(input logic [2:0] act, input logic [KEYS-1:0] keys,
                          input logic [31:0] stamp, input logic [KEY_W-1:0] sel);
    while ($urandom_range(0, 99) < gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {3'b000, sel, stamp, keys};
    do @(posedge clk); while (!s_tready);
  endtask

  // drain, then write the window while nothing is in flight
  task automatic set_window(input logic [DEB_W-1:0] ms);
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= ms;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    window = ms;
  endtask

  function automatic logic [31:0] sample_spacing();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 3) return $urandom;   // big jumps: wrap and held-time saturation
    if (r < 25) return 32'(window) + $urandom_range(0, 3);
    return $urandom_range(0, window / 2 + 2);
  endfunction

  // mostly samples that follow a slowly moving key pattern, with bounces
  task automatic random_beat();
    int unsigned     pick;
    int unsigned     k;
    logic [2:0]      act;
    logic [KEYS-1:0] keys;
    logic [31:0]     stamp;
    pick  = $urandom_range(0, 99);
    act   = ACT_SAMPLE;
    stamp = $urandom;
    keys  = KEYS'($urandom);
    if (pick < 90 - pop_share) begin
      if ($urandom_range(0, 9) == 0) begin
        k = $urandom_range(0, KEYS - 1);
        target[k] = ~target[k];
      end
      keys = target;
      if ($urandom_range(0, 6) == 0) keys = target ^ KEYS'($urandom_range(1, 7));
      now_ms = now_ms + sample_spacing();
      stamp  = now_ms;
    end else if (pick < 90) begin
      act = ACT_POP;
    end else if (pick < 93) begin
      act = ACT_FLUSH;
    end else if (pick < 96) begin
      act = ACT_CLEAR;
    end else if (pick < 98) begin
      act    = ACT_START;
      target = keys;
      now_ms = stamp;
    end else begin
      act = 3'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST));
    end
    put_beat(act, keys, stamp, KEY_W'($urandom));
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // before start: samples ignored, pops empty, spare codes report status only
    put_beat(ACT_SAMPLE, 3'b111, 32'h1234_5678, 2'd3);
    put_beat(ACT_POP, 3'b000, 32'h0, 2'd0);
    put_beat(ACT_SPARE_FIRST, 3'b010, 32'hFFFF_FFFF, 2'd1);
    // start just below the wrap, a bounce on key 2, then a release across the wrap
    put_beat(ACT_START, 3'b101, 32'hFFFF_FFF0, 2'd0);
    put_beat(ACT_SAMPLE, 3'b101, 32'hFFFF_FFF5, 2'd2);
    put_beat(ACT_SAMPLE, 3'b001, 32'hFFFF_FFF8, 2'd2);
    put_beat(ACT_SAMPLE, 3'b101, 32'hFFFF_FFFA, 2'd2);
    put_beat(ACT_SAMPLE, 3'b001, 32'h0000_0003, 2'd2);
    put_beat(ACT_SAMPLE, 3'b001, 32'h0000_0020, 2'd2);
    put_beat(ACT_POP, 3'b000, 32'h0, 2'd2);
    put_beat(ACT_POP, 3'b000, 32'h0, 2'd2);
    put_beat(ACT_CLEAR, 3'b000, 32'h0, 2'd2);
    // nine events into an eight-deep queue: one drop
    put_beat(ACT_START, 3'b000, 32'd1000, 2'd0);
    put_beat(ACT_SAMPLE, 3'b111, 32'd1001, 2'd0);
    put_beat(ACT_SAMPLE, 3'b111, 32'd1021, 2'd1);
    put_beat(ACT_SAMPLE, 3'b000, 32'd1022, 2'd0);
    put_beat(ACT_SAMPLE, 3'b000, 32'd1042, 2'd1);
    put_beat(ACT_SAMPLE, 3'b111, 32'd1043, 2'd0);
    put_beat(ACT_SAMPLE, 3'b111, 32'd1063, 2'd2);
    put_beat(ACT_POP, 3'b000, 32'h0, 2'd0);
    put_beat(ACT_FLUSH, 3'b000, 32'h0, 2'd0);
    // release after a long hold: held time saturates
    put_beat(ACT_SAMPLE, 3'b110, 32'd71063, 2'd0);
    put_beat(ACT_SAMPLE, 3'b110, 32'd71083, 2'd0);
    put_beat(ACT_POP, 3'b000, 32'h0, 2'd0);
    put_beat(ACT_SPARE_LAST, 3'b101, 32'h8000_0000, 2'd3);

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          set_window('0);
          gap_pct = 0;  stall_pct <= 0;  pop_share = 22;
        end
        1: begin
          set_window('1);
          gap_pct = 87; stall_pct <= 0;  pop_share = 22;
        end
        2: begin
          set_window(DEB_W'(3));
          gap_pct = 0;  stall_pct <= 87; pop_share = 4;
        end
        3: begin
          set_window(DEB_W'($urandom_range(1, 100)));
          gap_pct = 12; stall_pct <= 12; pop_share = 22;
        end
        4: begin
          set_window(DEBOUNCE_RESET);
          gap_pct = 0;  stall_pct <= 0;  pop_share = 22;
        end
        default: begin
          set_window(DEB_W'($urandom_range(0, 65535)));
          gap_pct = 12; stall_pct <= 12; pop_share = 10;
        end
      endcase
      target = KEYS'($urandom);
      now_ms = $urandom;
      put_beat(ACT_START, target, now_ms, KEY_W'($urandom));
      for (int n = 1; n < PHASE_BEATS; n++) begin
        // long output hold-offs while input keeps coming
        if (ph == 4 && (n == 40 || n == 100)) squeeze_ask <= squeeze_ask + 1;
        random_beat();
      end
    end

    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
    if (fails == 0) begin
      $display("key_debounce_event_queue verification clean");
    end else begin
      $display("key_debounce_event_queue verification failed");
    end
    $finish;
  end

endmodule

>>> key_debounce_event_queue.f
hw/rtl/kdeq_pkg.sv
hw/rtl/key_debounce_event_queue.sv
tb/sv/kdeq_event_checker.sv
tb/sv/tb_top.sv
